// File: hdl/rgb_to_hsv_convert_top_defines.svh
// assertion macros for the rgb to hsv converter checker
// expects clk and rst_n in the scope of use
`ifndef RGB_TO_HSV_CONVERT_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_TOP_DEFINES_SVH

// same-cycle implication
`define RHC_ASSERT_NOW(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rhc check failed");

// next-cycle implication
`define RHC_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rhc check failed");

`endif

// File: hdl/rhc_pkg.sv
// shared types and width constants for the rgb to hsv converter
// no dependencies
`timescale 1ns / 1ps

package rhc_pkg;

    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    // extra bits over channel + hue width for the hue dividend
    localparam int HUE_NUM_PAD = 4;
    // extra bits over channel width for the hue divisor (12 * delta)
    localparam int HUE_DEN_PAD = 4;
    // extra bit over twice the channel width for the saturation dividend
    localparam int SAT_NUM_PAD = 1;
    // extra bit over channel width for the saturation divisor (2 * max)
    localparam int SAT_DEN_PAD = 1;

endpackage

// File: hdl/rhc_front.sv
// front end: max/min/sector stage, then dividend and divisor build stage
// depends on rhc_pkg
`timescale 1ns / 1ps

module rhc_front #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS = 16,
    localparam int HN_W = CHANNEL_BITS + HUE_BITS + rhc_pkg::HUE_NUM_PAD,
    localparam int HD_W = CHANNEL_BITS + rhc_pkg::HUE_DEN_PAD,
    localparam int SN_W = 2 * CHANNEL_BITS + rhc_pkg::SAT_NUM_PAD,
    localparam int SD_W = CHANNEL_BITS + rhc_pkg::SAT_DEN_PAD
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    input  logic [CHANNEL_BITS-1:0] alpha_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HN_W-1:0]         hue_num,
    output logic [HD_W-1:0]         hue_den,
    output logic [SN_W-1:0]         sat_num,
    output logic [SD_W-1:0]         sat_den,
    output logic [CHANNEL_BITS-1:0] bright,
    output logic [CHANNEL_BITS-1:0] alpha,
    output logic                    hue_ok
);

    localparam int C  = CHANNEL_BITS;
    localparam int NW = C + rhc_pkg::HUE_DEN_PAD;

    // stage 1
    logic                  v1_reg;
    logic [C-1:0]          r1_reg;
    logic [C-1:0]          g1_reg;
    logic [C-1:0]          b1_reg;
    logic [C-1:0]          a1_reg;
    logic [C-1:0]          mx1_reg;
    logic [C-1:0]          mn1_reg;
    rhc_pkg::sector_t      sec1_reg;
    logic [C-1:0]          mx1_next;
    logic [C-1:0]          mn1_next;
    rhc_pkg::sector_t      sec1_next;

    // stage 2
    logic                  v2_reg;
    logic [HN_W-1:0]       hnum_reg;
    logic [HD_W-1:0]       hden_reg;
    logic [SN_W-1:0]       snum_reg;
    logic [SD_W-1:0]       sden_reg;
    logic [C-1:0]          bright_reg;
    logic [C-1:0]          alpha_reg;
    logic                  hok_reg;
    logic [HN_W-1:0]       hnum_next;
    logic [HD_W-1:0]       hden_next;
    logic [SN_W-1:0]       snum_next;
    logic [SD_W-1:0]       sden_next;
    logic                  hok_next;

    logic                  rdy1;
    logic                  rdy2;
    logic [C-1:0]          delta;
    logic [NW-1:0]         d_ext;
    logic [NW-1:0]         six_d;
    logic [NW-1:0]         off;
    logic [C-1:0]          xa;
    logic [C-1:0]          ya;
    logic [NW-1:0]         n_raw;
    logic [NW-1:0]         n_fix;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // largest channel picks the sector, red then green win ties
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sec1_next = rhc_pkg::SECTOR_RED;
            mx1_next  = red;
        end
        else if (green >= blue)
        begin
            sec1_next = rhc_pkg::SECTOR_GREEN;
            mx1_next  = green;
        end
        else
        begin
            sec1_next = rhc_pkg::SECTOR_BLUE;
            mx1_next  = blue;
        end
        mn1_next = (red < green) ? red : green;
        if (blue < mn1_next)
        begin
            mn1_next = blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            r1_reg   <= red;
            g1_reg   <= green;
            b1_reg   <= blue;
            a1_reg   <= alpha_in;
            mx1_reg  <= mx1_next;
            mn1_reg  <= mn1_next;
            sec1_reg <= sec1_next;
        end
    end

    // hue numerator in sixths times delta, wrapped into 0 .. 6*delta
    always_comb
    begin
        delta = mx1_reg - mn1_reg;
        d_ext = NW'(delta);
        six_d = (d_ext << 2) + (d_ext << 1);
        case (sec1_reg)
            rhc_pkg::SECTOR_GREEN:
            begin
                off = d_ext << 1;
                xa  = b1_reg;
                ya  = r1_reg;
            end
            rhc_pkg::SECTOR_BLUE:
            begin
                off = d_ext << 2;
                xa  = r1_reg;
                ya  = g1_reg;
            end
            default:
            begin
                off = '0;
                xa  = g1_reg;
                ya  = b1_reg;
            end
        endcase
        n_raw = off + NW'(xa) - NW'(ya);
        n_fix = n_raw[NW-1] ? (n_raw + six_d) : n_raw;

        hnum_next = {n_fix[C+2:0], {(HUE_BITS + 1){1'b0}}} + HN_W'(six_d);
        hden_next = HD_W'(six_d << 1);
        snum_next = {delta, {(C + 1){1'b0}}} - SN_W'({delta, 1'b0}) + SN_W'(mx1_reg);
        sden_next = {mx1_reg, 1'b0};
        hok_next  = (delta != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            hnum_reg   <= hnum_next;
            hden_reg   <= hden_next;
            snum_reg   <= snum_next;
            sden_reg   <= sden_next;
            bright_reg <= mx1_reg;
            alpha_reg  <= a1_reg;
            hok_reg    <= hok_next;
        end
    end

    assign out_valid = v2_reg;
    assign hue_num   = hnum_reg;
    assign hue_den   = hden_reg;
    assign sat_num   = snum_reg;
    assign sat_den   = sden_reg;
    assign bright    = bright_reg;
    assign alpha     = alpha_reg;
    assign hue_ok    = hok_reg;

endmodule

// File: hdl/rhc_div_pipe.sv
// pipelined restoring dividers for hue and saturation, one quotient bit per stage
// depends on rhc_pkg
`timescale 1ns / 1ps

module rhc_div_pipe #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS = 16,
    localparam int HQ   = HUE_BITS + 1,
    localparam int HN_W = CHANNEL_BITS + HUE_BITS + rhc_pkg::HUE_NUM_PAD,
    localparam int HD_W = CHANNEL_BITS + rhc_pkg::HUE_DEN_PAD,
    localparam int SN_W = 2 * CHANNEL_BITS + rhc_pkg::SAT_NUM_PAD,
    localparam int SD_W = CHANNEL_BITS + rhc_pkg::SAT_DEN_PAD
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [HN_W-1:0]         hue_num,
    input  logic [HD_W-1:0]         hue_den,
    input  logic [SN_W-1:0]         sat_num,
    input  logic [SD_W-1:0]         sat_den,
    input  logic [CHANNEL_BITS-1:0] bright,
    input  logic [CHANNEL_BITS-1:0] alpha,
    input  logic                    hue_ok,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HQ-1:0]           hue_quo,
    output logic [CHANNEL_BITS-1:0] sat_quo,
    output logic [CHANNEL_BITS-1:0] out_bright,
    output logic [CHANNEL_BITS-1:0] out_alpha,
    output logic                    out_hue_ok
);

    localparam int C  = CHANNEL_BITS;
    localparam int NS = (HQ > C) ? HQ : C;

    wire                v_s    [0:NS];
    wire                rdy    [0:NS];
    wire [HN_W-1:0]     hrem_s [0:NS];
    wire [HD_W-1:0]     hden_s [0:NS];
    wire [HQ-1:0]       hq_s   [0:NS];
    wire [SN_W-1:0]     srem_s [0:NS];
    wire [SD_W-1:0]     sden_s [0:NS];
    wire [C-1:0]        sq_s   [0:NS];
    wire [C-1:0]        br_s   [0:NS];
    wire [C-1:0]        al_s   [0:NS];
    wire                hok_s  [0:NS];

    assign v_s[0]    = in_valid;
    assign hrem_s[0] = hue_num;
    assign hden_s[0] = hue_den;
    assign hq_s[0]   = '0;
    assign srem_s[0] = sat_num;
    assign sden_s[0] = sat_den;
    assign sq_s[0]   = '0;
    assign br_s[0]   = bright;
    assign al_s[0]   = alpha;
    assign hok_s[0]  = hue_ok;
    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic              v_reg;
        logic [HN_W-1:0]   hrem_reg;
        logic [HD_W-1:0]   hden_reg;
        logic [HQ-1:0]     hq_reg;
        logic [SN_W-1:0]   srem_reg;
        logic [SD_W-1:0]   sden_reg;
        logic [C-1:0]      sq_reg;
        logic [C-1:0]      br_reg;
        logic [C-1:0]      al_reg;
        logic              hok_reg;
        logic [HN_W-1:0]   hrem_next;
        logic [HQ-1:0]     hq_next;
        logic [SN_W-1:0]   srem_next;
        logic [C-1:0]      sq_next;

        if (k < HQ)
        begin : g_hue
            logic [HN_W-1:0] hsub;
            assign hsub = HN_W'(hden_s[k]) << (HQ - 1 - k);
            always_comb
            begin
                if (hrem_s[k] >= hsub)
                begin
                    hrem_next = hrem_s[k] - hsub;
                    hq_next   = {hq_s[k][HQ-2:0], 1'b1};
                end
                else
                begin
                    hrem_next = hrem_s[k];
                    hq_next   = {hq_s[k][HQ-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_hue_hold
            assign hrem_next = hrem_s[k];
            assign hq_next   = hq_s[k];
        end

        if (k < C)
        begin : g_sat
            logic [SN_W-1:0] ssub;
            assign ssub = SN_W'(sden_s[k]) << (C - 1 - k);
            always_comb
            begin
                if (srem_s[k] >= ssub)
                begin
                    srem_next = srem_s[k] - ssub;
                    sq_next   = {sq_s[k][C-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_s[k];
                    sq_next   = {sq_s[k][C-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_sat_hold
            assign srem_next = srem_s[k];
            assign sq_next   = sq_s[k];
        end

        assign rdy[k] = !v_reg || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg <= v_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_s[k])
            begin
                hrem_reg <= hrem_next;
                hden_reg <= hden_s[k];
                hq_reg   <= hq_next;
                srem_reg <= srem_next;
                sden_reg <= sden_s[k];
                sq_reg   <= sq_next;
                br_reg   <= br_s[k];
                al_reg   <= al_s[k];
                hok_reg  <= hok_s[k];
            end
        end

        assign v_s[k+1]    = v_reg;
        assign hrem_s[k+1] = hrem_reg;
        assign hden_s[k+1] = hden_reg;
        assign hq_s[k+1]   = hq_reg;
        assign srem_s[k+1] = srem_reg;
        assign sden_s[k+1] = sden_reg;
        assign sq_s[k+1]   = sq_reg;
        assign br_s[k+1]   = br_reg;
        assign al_s[k+1]   = al_reg;
        assign hok_s[k+1]  = hok_reg;
    end

    assign out_valid  = v_s[NS];
    assign hue_quo    = hq_s[NS];
    assign sat_quo    = sq_s[NS];
    assign out_bright = br_s[NS];
    assign out_alpha  = al_s[NS];
    assign out_hue_ok = hok_s[NS];

endmodule

// File: hdl/rhc_out.sv
// output register: hue wrap, grey and black masking, result beat holding
// no package dependencies
`timescale 1ns / 1ps

module rhc_out #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [HUE_BITS:0]       hue_quo,
    input  logic [CHANNEL_BITS-1:0] sat_quo,
    input  logic [CHANNEL_BITS-1:0] bright,
    input  logic [CHANNEL_BITS-1:0] alpha,
    input  logic                    hue_ok,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HUE_BITS-1:0]     hue,
    output logic [CHANNEL_BITS-1:0] saturation,
    output logic [CHANNEL_BITS-1:0] brightness,
    output logic [CHANNEL_BITS-1:0] alpha_out,
    output logic                    hue_valid
);

    logic                    valid_reg;
    logic [HUE_BITS-1:0]     hue_reg;
    logic [CHANNEL_BITS-1:0] sat_reg;
    logic [CHANNEL_BITS-1:0] bright_reg;
    logic [CHANNEL_BITS-1:0] alpha_reg;
    logic                    hv_reg;
    logic [HUE_BITS-1:0]     hue_next;
    logic [CHANNEL_BITS-1:0] sat_next;

    assign in_ready = !valid_reg || out_ready;

    // a full turn reads zero
    always_comb
    begin
        hue_next = (hue_ok && !hue_quo[HUE_BITS]) ? hue_quo[HUE_BITS-1:0] : '0;
        sat_next = hue_ok ? sat_quo : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= bright;
            alpha_reg  <= alpha;
            hv_reg     <= hue_ok;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;
    assign alpha_out  = alpha_reg;
    assign hue_valid  = hv_reg;

endmodule

// File: hdl/rgb_to_hsv_convert_top.sv
// Converts one RGBA pixel per beat to hue, saturation and value with alpha
// passed through. Takes a new pixel every clock while the output side is not
// stalled. The pipeline holds the hue divider, which resolves one quotient bit
// per pipeline stage (HUE_BITS + 1 stages), with the saturation divider running
// alongside, two front stages for max/min and operand build, and one output
// register. Black and grey pixels give hue 0 with the hue_valid flag low. No
// setup after reset.
// depends on rhc_pkg, rhc_front, rhc_div_pipe, rhc_out
`timescale 1ns / 1ps

module rgb_to_hsv_convert_top #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS = 16,
    localparam int IN_W  = ((4 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((HUE_BITS + 3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // red, green, blue, alpha_in, zero pad
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // hue, saturation, brightness, alpha_out, zero pad
    output logic [0:0]       m_axis_tuser    // hue_valid
);

    localparam int C    = CHANNEL_BITS;
    localparam int HN_W = C + HUE_BITS + rhc_pkg::HUE_NUM_PAD;
    localparam int HD_W = C + rhc_pkg::HUE_DEN_PAD;
    localparam int SN_W = 2 * C + rhc_pkg::SAT_NUM_PAD;
    localparam int SD_W = C + rhc_pkg::SAT_DEN_PAD;

    logic [C-1:0]        red;
    logic [C-1:0]        green;
    logic [C-1:0]        blue;
    logic [C-1:0]        alpha_in;

    logic                f_valid;
    logic                f_ready;
    logic [HN_W-1:0]     f_hnum;
    logic [HD_W-1:0]     f_hden;
    logic [SN_W-1:0]     f_snum;
    logic [SD_W-1:0]     f_sden;
    logic [C-1:0]        f_bright;
    logic [C-1:0]        f_alpha;
    logic                f_hok;

    logic                d_valid;
    logic                d_ready;
    logic [HUE_BITS:0]   d_hq;
    logic [C-1:0]        d_sq;
    logic [C-1:0]        d_bright;
    logic [C-1:0]        d_alpha;
    logic                d_hok;

    logic [HUE_BITS-1:0] hue;
    logic [C-1:0]        saturation;
    logic [C-1:0]        brightness;
    logic [C-1:0]        alpha_out;
    logic                hue_valid;

    assign red      = s_axis_tdata[C-1:0];
    assign green    = s_axis_tdata[2*C-1:C];
    assign blue     = s_axis_tdata[3*C-1:2*C];
    assign alpha_in = s_axis_tdata[4*C-1:3*C];

    rhc_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_BITS     (HUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha_in  (alpha_in),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .hue_num   (f_hnum),
        .hue_den   (f_hden),
        .sat_num   (f_snum),
        .sat_den   (f_sden),
        .bright    (f_bright),
        .alpha     (f_alpha),
        .hue_ok    (f_hok)
    );

    rhc_div_pipe #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_BITS     (HUE_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .hue_num    (f_hnum),
        .hue_den    (f_hden),
        .sat_num    (f_snum),
        .sat_den    (f_sden),
        .bright     (f_bright),
        .alpha      (f_alpha),
        .hue_ok     (f_hok),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .hue_quo    (d_hq),
        .sat_quo    (d_sq),
        .out_bright (d_bright),
        .out_alpha  (d_alpha),
        .out_hue_ok (d_hok)
    );

    rhc_out #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_BITS     (HUE_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .hue_quo    (d_hq),
        .sat_quo    (d_sq),
        .bright     (d_bright),
        .alpha      (d_alpha),
        .hue_ok     (d_hok),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .alpha_out  (alpha_out),
        .hue_valid  (hue_valid)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[HUE_BITS-1:0]                  = hue;
        m_axis_tdata[HUE_BITS+C-1:HUE_BITS]         = saturation;
        m_axis_tdata[HUE_BITS+2*C-1:HUE_BITS+C]     = brightness;
        m_axis_tdata[HUE_BITS+3*C-1:HUE_BITS+2*C]   = alpha_out;
        m_axis_tuser[0]                             = hue_valid;
    end

endmodule

// File: hdl/rhc_checker.sv
// port-level checks on the result stream of the rgb to hsv converter
// depends on rgb_to_hsv_convert_top_defines.svh, bound to rgb_to_hsv_convert_top
`timescale 1ns / 1ps
`include "rgb_to_hsv_convert_top_defines.svh"

module rhc_checker #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS = 16,
    localparam int OUT_W = ((HUE_BITS + 3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [0:0]       m_axis_tuser
);

    localparam int C = CHANNEL_BITS;

    logic [HUE_BITS-1:0] hue;
    logic [C-1:0]        sat;
    logic [C-1:0]        bright;
    logic [OUT_W:0]      beat;

    assign hue    = m_axis_tdata[HUE_BITS-1:0];
    assign sat    = m_axis_tdata[HUE_BITS+C-1:HUE_BITS];
    assign bright = m_axis_tdata[HUE_BITS+2*C-1:HUE_BITS+C];
    assign beat   = {m_axis_tuser, m_axis_tdata};

    `RHC_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RHC_ASSERT_NEXT(a_beat_hold, m_axis_tvalid && !m_axis_tready, $stable(beat))
    `RHC_ASSERT_NOW(a_grey_zero, m_axis_tvalid && !m_axis_tuser[0], hue == '0 && sat == '0)
    `RHC_ASSERT_NOW(a_hue_lit, m_axis_tvalid && m_axis_tuser[0], bright != '0 && sat != '0)

endmodule

bind rgb_to_hsv_convert_top rhc_checker #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .HUE_BITS     (HUE_BITS)
) u_rhc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb.sv
// testbench for rgb_to_hsv_convert_top: directed and random pixels against a scoreboard
// that predicts hue, saturation, value and alpha, with random stalls on both stream sides
// depends on rhc_pkg and the rgb_to_hsv_convert_top rtl
`timescale 1ns / 1ps

module tb;

    localparam int CH_BITS        = 8;
    localparam int HUE_W          = 16;
    localparam int CMAX           = (1 << CH_BITS) - 1;
    localparam int IN_W           = 32;
    localparam int OUT_W          = 40;
    localparam int LATENCY        = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1800;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [CH_BITS-1:0] sat;
        logic [CH_BITS-1:0] bright;
        logic [CH_BITS-1:0] alpha;
        logic               hue_valid;
    } hsv_t;

    class hsv_scoreboard;
        hsv_t pending_hsv_q[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a);
            hsv_t             res;
            rhc_pkg::sector_t sector;
            longint           mx;
            longint           mn;
            longint           delta;
            longint           num;
            longint           hue_wide;
            mx = longint'(r);
            if (longint'(g) > mx) mx = longint'(g);
            if (longint'(b) > mx) mx = longint'(b);
            mn = longint'(r);
            if (longint'(g) < mn) mn = longint'(g);
            if (longint'(b) < mn) mn = longint'(b);
            delta = mx - mn;
            res.hue = '0;
            res.sat = '0;
            res.bright = mx[CH_BITS-1:0];
            res.alpha = a;
            res.hue_valid = 1'b0;
            if (mx != 0) begin
                hue_wide = (2 * CMAX * delta + mx) / (2 * mx);
                res.sat = hue_wide[CH_BITS-1:0];
            end
            if (delta != 0) begin
                if (longint'(r) == mx) sector = rhc_pkg::SECTOR_RED;
                else if (longint'(g) == mx) sector = rhc_pkg::SECTOR_GREEN;
                else sector = rhc_pkg::SECTOR_BLUE;
                case (sector)
                    rhc_pkg::SECTOR_RED:   num = longint'(g) - longint'(b);
                    rhc_pkg::SECTOR_GREEN: num = 2 * delta + (longint'(b) - longint'(r));
                    default:               num = 4 * delta + (longint'(r) - longint'(g));
                endcase
                if (num < 0) num = num + 6 * delta;
                hue_wide = (2 * num * (longint'(1) << HUE_W) + 6 * delta) / (12 * delta);
                if (hue_wide >= (longint'(1) << HUE_W)) hue_wide = 0;
                res.hue = hue_wide[HUE_W-1:0];
                res.hue_valid = 1'b1;
            end
            return res;
        endfunction

        function void note_pixel(logic [IN_W-1:0] px);
            pending_hsv_q.push_back(convert_pixel(px[7:0], px[15:8], px[23:16], px[31:24]));
        endfunction

        function int pending();
            return pending_hsv_q.size();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_result(logic [OUT_W-1:0] data, logic flag);
            hsv_t want;
            if (pending_hsv_q.size() == 0) begin
                report($sformatf("result beat 0x%h with no pixel pending", data));
            end
            else begin
                want = pending_hsv_q.pop_front();
                if (data[15:0] !== want.hue)
                    report($sformatf("hue 0x%h, predicted 0x%h", data[15:0], want.hue));
                if (data[23:16] !== want.sat)
                    report($sformatf("saturation %0d, predicted %0d", data[23:16], want.sat));
                if (data[31:24] !== want.bright)
                    report($sformatf("brightness %0d, predicted %0d", data[31:24], want.bright));
                if (data[39:32] !== want.alpha)
                    report($sformatf("alpha %0d, predicted %0d", data[39:32], want.alpha));
                if (flag !== want.hue_valid)
                    report($sformatf("hue_valid %b, predicted %b", flag, want.hue_valid));
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [0:0]       m_axis_tuser;

    hsv_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int idle_cycles;

    rgb_to_hsv_convert_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_pixel(input logic [IN_W-1:0] px);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_rgba(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a);
        send_pixel({a, b, g, r});
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [IN_W-1:0] random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        int kind;
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        a = 8'($urandom_range(0, 255));
        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                // grey or black
                if ($urandom_range(0, 3) == 0) r = 8'd0;
                g = r;
                b = r;
            end
            1:
            begin
                // two channels tied at the top
                case ($urandom_range(0, 2))
                    0: begin g = r; if (b > r) b = r; end
                    1: begin b = g; if (r > g) r = g; end
                    default: begin b = r; if (g > r) g = r; end
                endcase
            end
            2:
            begin
                // channels close together
                r = 8'($urandom_range(0, 249));
                g = r + 8'($urandom_range(0, 5));
                b = r + 8'($urandom_range(0, 5));
            end
            default: ;
        endcase
        return {a, b, g, r};
    endfunction

    initial
    begin
        int i;
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        hold_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_rgba(8'd0,   8'd0,   8'd0,   8'd0);
        send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
        send_rgba(8'd128, 8'd128, 8'd128, 8'd17);
        send_rgba(8'd255, 8'd0,   8'd0,   8'd255);
        send_rgba(8'd0,   8'd255, 8'd0,   8'd0);
        send_rgba(8'd0,   8'd0,   8'd255, 8'd128);
        send_rgba(8'd255, 8'd255, 8'd0,   8'd1);
        send_rgba(8'd0,   8'd255, 8'd255, 8'd254);
        send_rgba(8'd255, 8'd0,   8'd255, 8'd85);
        send_rgba(8'd255, 8'd0,   8'd1,   8'd170);
        send_rgba(8'd1,   8'd0,   8'd0,   8'd3);
        send_rgba(8'd255, 8'd254, 8'd254, 8'd200);
        send_rgba(8'd2,   8'd1,   8'd1,   8'd99);
        send_rgba(8'd1,   8'd1,   8'd0,   8'd64);
        send_rgba(8'd0,   8'd1,   8'd1,   8'd32);
        send_rgba(8'd255, 8'd1,   8'd0,   8'd16);
        send_rgba(8'd0,   8'd0,   8'd1,   8'd8);
        send_rgba(8'd10,  8'd200, 8'd90,  8'd4);
        send_rgba(8'd200, 8'd90,  8'd10,  8'd2);
        send_rgba(8'd90,  8'd10,  8'd200, 8'd127);
        send_rgba(8'd254, 8'd255, 8'd0,   8'd240);
        drain_results();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 50;
            end
            if (i == 600)
            begin
                // long receiver hold-off while the sender keeps pushing
                hold_req = 1'b1;
                tx_idle_pct = 0;
            end
            if (i == 700)
            begin
                drain_results();
                tx_idle_pct = 40;
                rx_idle_pct = 10;
            end
            if (i == 1000)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 1100)
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 25;
            end
            if (i == 1500)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_pixel(random_pixel());
        end

        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

endmodule

// File: rgb_to_hsv_convert_top.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_div_pipe.sv
hdl/rhc_out.sv
hdl/rgb_to_hsv_convert_top.sv
hdl/rhc_checker.sv
tb/tb.sv
